### hw/rtl/ffha_pkg.sv
// Shared types, codes and helpers for the first-fit hole allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ffha_pkg;

    // Field widths: byte addresses and a wider form for unclipped sums
    localparam int AW = 48;
    localparam int WW = 50;

    typedef logic [AW-1:0] addr_t;
    typedef logic [WW-1:0] wide_t;

    // One table entry
    typedef struct packed {
        addr_t start;
        addr_t size;
    } hole_t;

    // Commands broadcast to the row of cells
    typedef logic [2:0] cmd_kind_t;
    localparam cmd_kind_t CMD_NOP    = 3'd0;
    localparam cmd_kind_t CMD_ROTATE = 3'd1;
    localparam cmd_kind_t CMD_WRITE  = 3'd2;
    localparam cmd_kind_t CMD_INSERT = 3'd3;
    localparam cmd_kind_t CMD_REMOVE = 3'd4;

    typedef struct packed {
        cmd_kind_t kind;
        hole_t     hole;
    } cell_cmd_t;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic REG_ZONE_BASE   = 1'b0;
    localparam logic REG_ZONE_LENGTH = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOFIT    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_MISALIGN = 2'd3;

    // Clip a wide size to the largest storable value
    function automatic addr_t sat_addr(input wide_t v);
        addr_t r;
        if (v[WW-1:AW] != '0)
            r = '1;
        else
            r = v[AW-1:0];
        return r;
    endfunction

endpackage

### hw/rtl/ffha_if.sv
// Request and response channel interfaces of the hole allocator.
// Depends on ffha_pkg for the payload types.
`timescale 1ns / 1ps

interface ffha_req_if import ffha_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  op;
    addr_t address;
    addr_t length;

    modport source (output valid, output op, output address, output length, input ready);
    modport sink   (input valid, input op, input address, input length, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
    logic    valid;
    logic    ready;
    addr_t   granted_address;
    status_t status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink   (input valid, input granted_address, input status, output ready);
endinterface

### hw/rtl/ffha_cell.sv
// One table cell: holds a hole and moves it to or from its neighbors.
// Depends on ffha_pkg for the entry and command types.
`timescale 1ns / 1ps

module ffha_cell import ffha_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cell_cmd_t       cmd,
    input  logic [IW-1:0]   idx,
    input  hole_t           prev_hole,
    input  hole_t           next_hole,
    output hole_t           hole
);

    hole_t         hole_reg;
    hole_t         hole_next;
    logic [IW-1:0] my_idx;

    assign my_idx = IW'(IDX);

    // Select the new content from the broadcast command
    always_comb
    begin
        hole_next = hole_reg;
        case (cmd.kind)
            CMD_ROTATE:
            begin
                hole_next = next_hole;
            end
            CMD_WRITE:
            begin
                if (my_idx == idx)
                    hole_next = cmd.hole;
            end
            CMD_INSERT:
            begin
                if (my_idx == idx)
                    hole_next = cmd.hole;
                else if (my_idx > idx)
                    hole_next = prev_hole;
            end
            CMD_REMOVE:
            begin
                if (my_idx >= idx)
                    hole_next = next_hole;
            end
            default:
            begin
                hole_next = hole_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hole_reg <= '0;
        else
            hole_reg <= hole_next;
    end

    assign hole = hole_reg;

endmodule

### hw/rtl/ffha_ctrl.sv
// Sequencer of the hole allocator: prepares a request, scans the rotating
// table at cell 0, decides the edit and drives the cell commands.
// Depends on ffha_pkg and the channel interfaces in ffha_if.
`timescale 1ns / 1ps

module ffha_ctrl import ffha_pkg::*; #(
    parameter int MAX_HOLES        = 128,
    parameter int LARGE_PAGE_SHIFT = 21,
    parameter int IW               = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  addr_t         cfg_data,
    ffha_req_if.sink      req,
    ffha_rsp_if.source    rsp,
    input  hole_t         head,
    output cell_cmd_t     cmd,
    output logic [IW-1:0] cmd_idx
);

    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_HOLES);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_HOLES - 1);
    localparam wide_t PMASK   = (WW'(1) << LARGE_PAGE_SHIFT) - WW'(1);
    localparam addr_t PMASK_A = PMASK[AW-1:0];

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP1 = 4'd1;
    localparam logic [3:0] S_PREP2 = 4'd2;
    localparam logic [3:0] S_PREP3 = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DEC1  = 4'd5;
    localparam logic [3:0] S_DEC2  = 4'd6;
    localparam logic [3:0] S_DEC3  = 4'd7;
    localparam logic [3:0] S_EDIT1 = 4'd8;
    localparam logic [3:0] S_EDIT2 = 4'd9;

    // Control state
    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          f_found_reg, f_found_next;
    logic          u_found_reg, u_found_next;
    logic          m_found_reg, m_found_next;
    logic          p_found_reg, p_found_next;

    // Payload state
    addr_t         zone_base_reg, zone_base_next;
    addr_t         zone_len_reg, zone_len_next;
    logic          op_reg, op_next;
    addr_t         addr_reg, addr_next;
    addr_t         len_reg, len_next;
    wide_t         size_reg, size_next;
    wide_t         need_reg, need_next;
    wide_t         bn_reg, bn_next;
    wide_t         tail_reg, tail_next;
    logic [IW-1:0] f_idx_reg, f_idx_next;
    addr_t         f_start_reg, f_start_next;
    addr_t         f_size_reg, f_size_next;
    wide_t         f_end_reg, f_end_next;
    logic [IW-1:0] u_idx_reg, u_idx_next;
    addr_t         u_start_reg, u_start_next;
    addr_t         u_size_reg, u_size_next;
    logic [IW-1:0] m_idx_reg, m_idx_next;
    addr_t         m_start_reg, m_start_next;
    addr_t         m_size_reg, m_size_next;
    logic [IW-1:0] p_idx_reg, p_idx_next;
    logic          hok_reg, hok_next;
    logic          split_reg, split_next;
    logic          tfree_reg, tfree_next;
    wide_t         diff_reg, diff_next;
    wide_t         add_reg, add_next;
    cell_cmd_t     ed1_reg, ed1_next;
    logic [IW-1:0] ed1_idx_reg, ed1_idx_next;
    cell_cmd_t     ed2_reg, ed2_next;
    logic [IW-1:0] ed2_idx_reg, ed2_idx_next;
    logic          inc_reg, inc_next;
    logic          dec_reg, dec_next;
    addr_t         grant_reg, grant_next;
    status_t       stat_reg, stat_next;
    addr_t         rsp_addr_reg, rsp_addr_next;
    status_t       rsp_stat_reg, rsp_stat_next;

    // Request-derived values
    addr_t base_a;
    addr_t off_a;
    logic  hint_on;
    wide_t target;

    // Scan of the head cell
    logic  head_valid;
    wide_t head_end;
    logic  is_f;
    logic  mod_f;
    wide_t eff_end;
    addr_t eff_size;
    logic  pos_hit;
    logic  is_m;
    logic  is_p;
    logic  is_u;

    // Decision helpers
    logic          out_free;
    logic          req_fire;
    logic          full;
    logic [IW-1:0] pos;
    addr_t         merged;
    addr_t         ins_size;
    logic [IW-1:0] c_idx;
    addr_t         c_start;
    addr_t         c_size;
    wide_t         c_need;
    cell_cmd_t     f_cut;

    assign base_a   = addr_reg & ~PMASK_A;
    assign off_a    = addr_reg & PMASK_A;
    assign hint_on  = (op_reg == OP_ALLOC) && (addr_reg != '0);
    assign target   = (op_reg == OP_FREE) ? WW'(addr_reg) : tail_reg;
    assign req_fire = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    // Compare the head entry against the request
    assign head_valid = (CW'(scan_reg) < count_reg) && (state_reg == S_SCAN);
    assign head_end   = WW'(head.start) + WW'(head.size);
    assign is_f       = head_valid && !f_found_reg && (WW'(head.size) >= need_reg);
    assign mod_f      = is_f && hint_on;
    assign eff_end    = mod_f ? WW'(base_a) : head_end;
    assign eff_size   = mod_f ? (base_a - head.start) : head.size;
    assign pos_hit    = (scan_reg == '0) ? (WW'(head.start) > target)
                                         : (WW'(head.start) >= target);
    assign is_m       = head_valid && !m_found_reg && (eff_end == target);
    assign is_p       = head_valid && !p_found_reg && pos_hit;
    assign is_u       = head_valid && !u_found_reg && (WW'(head.size) >= size_reg);

    // Edit operands
    assign full     = (count_reg == MAX_CNT);
    assign pos      = p_found_reg ? p_idx_reg : count_reg[IW-1:0];
    assign merged   = sat_addr(WW'(m_size_reg) + add_reg);
    assign ins_size = sat_addr(add_reg);
    assign c_idx    = hok_reg ? f_idx_reg : u_idx_reg;
    assign c_start  = hok_reg ? f_start_reg : u_start_reg;
    assign c_size   = hok_reg ? f_size_reg : u_size_reg;
    assign c_need   = hok_reg ? need_reg : size_reg;
    assign f_cut    = '{kind: CMD_WRITE,
                        hole: '{start: f_start_reg, size: base_a - f_start_reg}};

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        f_found_next   = f_found_reg;
        u_found_next   = u_found_reg;
        m_found_next   = m_found_reg;
        p_found_next   = p_found_reg;
        zone_base_next = zone_base_reg;
        zone_len_next  = zone_len_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        size_next      = size_reg;
        need_next      = need_reg;
        bn_next        = bn_reg;
        tail_next      = tail_reg;
        f_idx_next     = f_idx_reg;
        f_start_next   = f_start_reg;
        f_size_next    = f_size_reg;
        f_end_next     = f_end_reg;
        u_idx_next     = u_idx_reg;
        u_start_next   = u_start_reg;
        u_size_next    = u_size_reg;
        m_idx_next     = m_idx_reg;
        m_start_next   = m_start_reg;
        m_size_next    = m_size_reg;
        p_idx_next     = p_idx_reg;
        hok_next       = hok_reg;
        split_next     = split_reg;
        tfree_next     = tfree_reg;
        diff_next      = diff_reg;
        add_next       = add_reg;
        ed1_next       = ed1_reg;
        ed1_idx_next   = ed1_idx_reg;
        ed2_next       = ed2_reg;
        ed2_idx_next   = ed2_idx_reg;
        inc_next       = inc_reg;
        dec_next       = dec_reg;
        grant_next     = grant_reg;
        stat_next      = stat_reg;
        rsp_addr_next  = rsp_addr_reg;
        rsp_stat_next  = rsp_stat_reg;

        // Drop the result once it is taken
        if (rsp.valid && rsp.ready)
            rsp_valid_next = 1'b0;

        // Reload the zone and restart the table with one hole
        if (cfg_we)
        begin
            if (cfg_index == REG_ZONE_BASE)
                zone_base_next = cfg_data;
            else
                zone_len_next = cfg_data;
            count_next = ONE_CNT;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next    = req.op;
                    addr_next  = req.address;
                    len_next   = req.length;
                    state_next = S_PREP1;
                end
            end
            S_PREP1:
            begin
                size_next    = (WW'(len_reg) + PMASK) & ~PMASK;
                f_found_next = 1'b0;
                u_found_next = 1'b0;
                m_found_next = 1'b0;
                p_found_next = 1'b0;
                state_next   = S_PREP2;
            end
            S_PREP2:
            begin
                need_next  = size_reg + WW'(off_a);
                state_next = S_PREP3;
            end
            S_PREP3:
            begin
                bn_next    = WW'(base_a) + need_reg;
                tail_next  = (WW'(base_a) + need_reg + PMASK) & ~PMASK;
                scan_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Record the first match of each search as the table passes by
                if (is_f)
                begin
                    f_found_next = 1'b1;
                    f_idx_next   = scan_reg;
                    f_start_next = head.start;
                    f_size_next  = head.size;
                    f_end_next   = head_end;
                end
                if (is_u)
                begin
                    u_found_next = 1'b1;
                    u_idx_next   = scan_reg;
                    u_start_next = head.start;
                    u_size_next  = head.size;
                end
                if (is_m)
                begin
                    m_found_next = 1'b1;
                    m_idx_next   = scan_reg;
                    m_start_next = head.start;
                    m_size_next  = eff_size;
                end
                if (is_p)
                begin
                    p_found_next = 1'b1;
                    p_idx_next   = scan_reg;
                end
                scan_next = scan_reg + IW'(1);
                if (scan_reg == LAST_IDX)
                    state_next = S_DEC1;
            end
            S_DEC1:
            begin
                hok_next   = hint_on && f_found_reg && (f_start_reg <= base_a)
                             && (f_end_reg >= bn_reg);
                split_next = (f_start_reg != base_a);
                tfree_next = (tail_reg < f_end_reg);
                diff_next  = f_end_reg - tail_reg;
                state_next = S_DEC2;
            end
            S_DEC2:
            begin
                if (op_reg == OP_FREE)
                    add_next = size_reg;
                else
                    add_next = (diff_reg + PMASK) & ~PMASK;
                state_next = S_DEC3;
            end
            S_DEC3:
            begin
                ed1_next     = '{kind: CMD_NOP, hole: '0};
                ed2_next     = '{kind: CMD_NOP, hole: '0};
                ed1_idx_next = '0;
                ed2_idx_next = '0;
                inc_next     = 1'b0;
                dec_next     = 1'b0;
                grant_next   = '0;
                stat_next    = ST_OK;
                if (op_reg == OP_FREE)
                begin
                    if (off_a != '0)
                        stat_next = ST_MISALIGN;
                    else if (m_found_reg)
                    begin
                        ed1_next     = '{kind: CMD_WRITE,
                                         hole: '{start: m_start_reg, size: merged}};
                        ed1_idx_next = m_idx_reg;
                    end
                    else if (full)
                        stat_next = ST_FULL;
                    else
                    begin
                        ed1_next     = '{kind: CMD_INSERT,
                                         hole: '{start: addr_reg, size: ins_size}};
                        ed1_idx_next = pos;
                        inc_next     = 1'b1;
                    end
                end
                else if (hok_reg && split_reg)
                begin
                    // Cut the hole back to the hint and free the tail again
                    grant_next = addr_reg;
                    if (!tfree_reg)
                    begin
                        ed1_next     = f_cut;
                        ed1_idx_next = f_idx_reg;
                    end
                    else if (m_found_reg)
                    begin
                        ed1_next     = f_cut;
                        ed1_idx_next = f_idx_reg;
                        ed2_next     = '{kind: CMD_WRITE,
                                         hole: '{start: m_start_reg, size: merged}};
                        ed2_idx_next = m_idx_reg;
                    end
                    else if (full)
                    begin
                        grant_next = '0;
                        stat_next  = ST_FULL;
                    end
                    else
                    begin
                        ed1_next     = f_cut;
                        ed1_idx_next = f_idx_reg;
                        ed2_next     = '{kind: CMD_INSERT,
                                         hole: '{start: tail_reg[AW-1:0], size: ins_size}};
                        ed2_idx_next = pos;
                        inc_next     = 1'b1;
                    end
                end
                else if (hok_reg || u_found_reg)
                begin
                    // Carve from the front; an emptied hole leaves the table
                    grant_next   = hok_reg ? addr_reg : u_start_reg;
                    ed1_idx_next = c_idx;
                    if (WW'(c_size) == c_need)
                    begin
                        ed1_next = '{kind: CMD_REMOVE, hole: '0};
                        dec_next = 1'b1;
                    end
                    else
                        ed1_next = '{kind: CMD_WRITE,
                                     hole: '{start: c_start + c_need[AW-1:0],
                                             size: c_size - c_need[AW-1:0]}};
                end
                else
                    stat_next = ST_NOFIT;
                state_next = S_EDIT1;
            end
            S_EDIT1:
            begin
                state_next = S_EDIT2;
            end
            S_EDIT2:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    if (inc_reg)
                        count_next = count_reg + ONE_CNT;
                    else if (dec_reg)
                        count_next = count_reg - ONE_CNT;
                    rsp_valid_next = 1'b1;
                    rsp_addr_next  = grant_reg;
                    rsp_stat_next  = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Cell command: a configuration write, a rotation step or an edit
    always_comb
    begin
        cmd     = '{kind: CMD_NOP, hole: '0};
        cmd_idx = '0;
        if (cfg_we)
        begin
            cmd.kind       = CMD_WRITE;
            cmd.hole.start = (cfg_index == REG_ZONE_BASE) ? cfg_data : zone_base_reg;
            cmd.hole.size  = (cfg_index == REG_ZONE_LENGTH) ? cfg_data : zone_len_reg;
        end
        else
        begin
            case (state_reg)
                S_SCAN:
                begin
                    cmd.kind = CMD_ROTATE;
                end
                S_EDIT1:
                begin
                    cmd     = ed1_reg;
                    cmd_idx = ed1_idx_reg;
                end
                S_EDIT2:
                begin
                    if (out_free)
                    begin
                        cmd     = ed2_reg;
                        cmd_idx = ed2_idx_reg;
                    end
                end
                default:
                begin
                    cmd.kind = CMD_NOP;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            count_reg     <= ONE_CNT;
            rsp_valid_reg <= 1'b0;
            f_found_reg   <= 1'b0;
            u_found_reg   <= 1'b0;
            m_found_reg   <= 1'b0;
            p_found_reg   <= 1'b0;
            zone_base_reg <= '0;
            zone_len_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            f_found_reg   <= f_found_next;
            u_found_reg   <= u_found_next;
            m_found_reg   <= m_found_next;
            p_found_reg   <= p_found_next;
            zone_base_reg <= zone_base_next;
            zone_len_reg  <= zone_len_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        size_reg     <= size_next;
        need_reg     <= need_next;
        bn_reg       <= bn_next;
        tail_reg     <= tail_next;
        f_idx_reg    <= f_idx_next;
        f_start_reg  <= f_start_next;
        f_size_reg   <= f_size_next;
        f_end_reg    <= f_end_next;
        u_idx_reg    <= u_idx_next;
        u_start_reg  <= u_start_next;
        u_size_reg   <= u_size_next;
        m_idx_reg    <= m_idx_next;
        m_start_reg  <= m_start_next;
        m_size_reg   <= m_size_next;
        p_idx_reg    <= p_idx_next;
        hok_reg      <= hok_next;
        split_reg    <= split_next;
        tfree_reg    <= tfree_next;
        diff_reg     <= diff_next;
        add_reg      <= add_next;
        ed1_reg      <= ed1_next;
        ed1_idx_reg  <= ed1_idx_next;
        ed2_reg      <= ed2_next;
        ed2_idx_reg  <= ed2_idx_next;
        inc_reg      <= inc_next;
        dec_reg      <= dec_next;
        grant_reg    <= grant_next;
        stat_reg     <= stat_next;
        rsp_addr_reg <= rsp_addr_next;
        rsp_stat_reg <= rsp_stat_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.granted_address = rsp_addr_reg;
    assign rsp.status          = rsp_stat_reg;

    // The hole count never exceeds the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("hole count beyond table size");

    // A full pass of the table always ends the scan
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_reg == LAST_IDX && !cfg_we) |=> state_reg == S_DEC1)
        else $error("scan did not end after one pass");

    // The count moves only on a finished request or a configuration write
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_EDIT2 || $past(cfg_we)))
        else $error("hole count changed outside an edit");

    // A table-full result only comes from a full table
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDIT2 && out_free && stat_reg == ST_FULL) |-> full)
        else $error("table full reported with free entries");

    // A grant is given only with an ok status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_addr_reg != '0) |-> rsp_stat_reg == ST_OK)
        else $error("nonzero grant with failure status");

endmodule

### hw/rtl/first_fit_hole_allocator.sv
// First-fit hole allocator: a row of MAX_HOLES cells, one hole each, rotated
// past cell 0 for a full pass on every request. A request runs through the
// prepare, scan, decide and edit states before its result is registered; a new
// request is taken only after the result of the last one has been registered.
// Reset gives an empty zone at 0 with one hole; a configuration write
// reloads the table to one hole spanning the zone from the next cycle on.
`timescale 1ns / 1ps

module first_fit_hole_allocator import ffha_pkg::*; #(
    parameter int MAX_HOLES        = 128,
    parameter int LARGE_PAGE_SHIFT = 21
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  addr_t      cfg_data,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);

    localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

    cell_cmd_t     cell_cmd;
    logic [IW-1:0] cell_idx;
    hole_t         cell_q [MAX_HOLES];

    // Sequencer and decision logic
    ffha_ctrl #(
        .MAX_HOLES        (MAX_HOLES),
        .LARGE_PAGE_SHIFT (LARGE_PAGE_SHIFT),
        .IW               (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .head      (cell_q[0]),
        .cmd       (cell_cmd),
        .cmd_idx   (cell_idx)
    );

    // Row of cells closed into a ring for the scan rotation
    for (genvar g = 0; g < MAX_HOLES; g++)
    begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == MAX_HOLES - 1) ? 0 : g + 1;

        ffha_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cell_cmd),
            .idx       (cell_idx),
            .prev_hole (cell_q[PREV]),
            .next_hole (cell_q[NEXT]),
            .hole      (cell_q[g])
        );
    end

endmodule

### bench/ffha_checker.sv
// Scoreboard for the first-fit hole allocator: mirrors the hole table and
// compares every result transfer. Depends on ffha_pkg and ffha_if.sv.
`timescale 1ns / 1ps

module ffha_checker import ffha_pkg::*; #(
    parameter int MAX_HOLES        = 128,
    parameter int LARGE_PAGE_SHIFT = 21
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  logic  cfg_index,
    input  addr_t cfg_data,
    ffha_req_if   req,
    ffha_rsp_if   rsp,
    output int    errors,
    output int    pending
);

    localparam bit [63:0] M48 = 64'h0000_FFFF_FFFF_FFFF;
    localparam bit [63:0] PGB = 64'd1 << LARGE_PAGE_SHIFT;
    localparam bit [63:0] PM  = PGB - 64'd1;

    typedef struct packed {
        addr_t   granted;
        status_t status;
    } grant_t;

    // Mirror of the hole table and the zone registers
    bit [63:0] hole_base [MAX_HOLES];
    bit [63:0] hole_len [MAX_HOLES];
    int        hole_cnt;
    bit [63:0] zone_lo;
    bit [63:0] zone_len;
    grant_t    grant_q[$];

    function automatic bit [63:0] clip48(bit [63:0] v);
        return (v > M48) ? M48 : v;
    endfunction

    function automatic bit [63:0] page_round(bit [63:0] len);
        bit [63:0] r;
        r = len & ~PM;
        if ((len & PM) != 0)
            r += PGB;
        return r;
    endfunction

    function automatic void reload_table();
        for (int i = 0; i < MAX_HOLES; i++)
        begin
            hole_base[i] = 0;
            hole_len[i] = 0;
        end
        hole_base[0] = zone_lo & M48;
        hole_len[0] = zone_len & M48;
        hole_cnt = 1;
    endfunction

    // Grow the hole that ends at addr, else insert a new one in address order
    function automatic status_t release_range(bit [63:0] addr, bit [63:0] sz);
        int pos;
        for (int i = 0; i < hole_cnt; i++)
        begin
            if (hole_base[i] + hole_len[i] == addr)
            begin
                hole_len[i] = clip48(hole_len[i] + sz);
                return ST_OK;
            end
        end
        if (hole_cnt >= MAX_HOLES)
            return ST_FULL;
        if (hole_cnt == 0 || hole_base[0] > addr)
            pos = 0;
        else
        begin
            pos = 1;
            while (pos < hole_cnt && hole_base[pos] < addr)
                pos++;
        end
        for (int i = hole_cnt; i > pos; i--)
        begin
            hole_base[i] = hole_base[i-1];
            hole_len[i] = hole_len[i-1];
        end
        hole_base[pos] = addr & M48;
        hole_len[pos] = clip48(sz);
        hole_cnt++;
        return ST_OK;
    endfunction

    // Take need bytes from the front of hole idx; drop the hole if emptied
    function automatic bit [63:0] carve_front(int idx, bit [63:0] need);
        bit [63:0] got;
        got = hole_base[idx];
        if (hole_len[idx] == need)
        begin
            for (int i = idx; i < hole_cnt - 1; i++)
            begin
                hole_base[i] = hole_base[i+1];
                hole_len[i] = hole_len[i+1];
            end
            hole_cnt--;
            hole_base[hole_cnt] = 0;
            hole_len[hole_cnt] = 0;
        end
        else
        begin
            hole_base[idx] = (got + need) & M48;
            hole_len[idx] -= need;
        end
        return got;
    endfunction

    function automatic bit find_fit(bit [63:0] need, output int idx);
        idx = 0;
        for (int i = 0; i < hole_cnt; i++)
        begin
            if (hole_len[i] >= need)
            begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one request to the mirror and produce its result
    function automatic grant_t serve_request(logic op, addr_t address, addr_t length);
        grant_t    r;
        bit [63:0] sz, off, base, need, old, oldend, tail;
        status_t   st;
        int        idx;
        r.granted = '0;
        r.status = ST_OK;
        sz = page_round(64'(length));
        if (op == OP_FREE)
        begin
            if ((64'(address) & PM) != 0)
                r.status = ST_MISALIGN;
            else
                r.status = release_range(64'(address), sz);
            return r;
        end
        if (address != 0)
        begin
            off = 64'(address) & PM;
            base = 64'(address) & ~PM;
            need = sz + off;
            if (find_fit(need, idx) && hole_base[idx] <= base
                && hole_base[idx] + hole_len[idx] >= base + need)
            begin
                if (hole_base[idx] != base)
                begin
                    // Cut the hole back to end at base, then give back the tail
                    old = hole_len[idx];
                    oldend = hole_base[idx] + old;
                    tail = (base + need + PM) & ~PM;
                    st = ST_OK;
                    hole_len[idx] = base - hole_base[idx];
                    if (tail < oldend)
                        st = release_range(tail, page_round(oldend - tail));
                    if (st != ST_OK)
                    begin
                        hole_len[idx] = old;
                        r.status = ST_FULL;
                        return r;
                    end
                    r.granted = addr_t'(base + off);
                    return r;
                end
                r.granted = addr_t'(carve_front(idx, need) + off);
                return r;
            end
        end
        if (find_fit(sz, idx))
            r.granted = addr_t'(carve_front(idx, sz));
        else
            r.status = ST_NOFIT;
        return r;
    endfunction

    // Compare result transfers, track configuration, predict request transfers
    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            zone_lo = 0;
            zone_len = 0;
            reload_table();
            grant_q.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (grant_q.size() == 0)
                begin
                    $display("%t: unexpected result addr=%h status=%0d", $time,
                             rsp.granted_address, rsp.status);
                    errors <= errors + 1;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp.granted_address !== want.granted || rsp.status !== want.status)
                    begin
                        $display("%t: mismatch expected addr=%h status=%0d, got addr=%h status=%0d",
                                 $time, want.granted, want.status,
                                 rsp.granted_address, rsp.status);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_ZONE_BASE)
                    zone_lo = 64'(cfg_data);
                else
                    zone_len = 64'(cfg_data);
                reload_table();
            end
            if (req.valid && req.ready)
                grant_q.push_back(serve_request(req.op, req.address, req.length));
            pending <= grant_q.size();
        end
    end

endmodule

### bench/tb_first_fit_hole_allocator.sv
// Testbench top for the first-fit hole allocator: clock, reset, zone setup,
// directed and random requests with random stalls. Needs ffha_pkg, ffha_if.sv,
// ffha_checker.sv and the block itself.
`timescale 1ns / 1ps

module tb_first_fit_hole_allocator;
    import ffha_pkg::*;

    localparam bit [63:0] PG  = 64'd1 << 21;
    localparam bit [63:0] PM  = PG - 64'd1;
    localparam addr_t     MAX = '1;

    typedef struct {
        logic  op;
        addr_t len;
    } sent_t;

    typedef struct {
        addr_t at;
        addr_t len;
    } block_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    logic  cfg_index;
    addr_t cfg_data;
    int    errors;
    int    pending;

    bit    quiet;
    addr_t zbase;
    addr_t zlen;
    int    n_alloc, n_free, n_zones;
    int    n_stat[4];
    sent_t  sent_q[$];
    block_t live_q[$];

    ffha_req_if req();
    ffha_rsp_if rsp();

    first_fit_hole_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    ffha_checker alloc_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall before each transfer
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    // Record grants so later frees can hand them back
    always @(posedge clk)
    begin
        sent_t s;
        if (rst_n && rsp.valid && rsp.ready && sent_q.size() > 0)
        begin
            s = sent_q.pop_front();
            n_stat[rsp.status]++;
            if (s.op == OP_ALLOC && rsp.status == ST_OK && live_q.size() < 64)
                live_q.push_back('{rsp.granted_address, s.len});
        end
    end

    task automatic send(logic op, addr_t address, addr_t length);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.address <= address;
        req.length <= length;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent_q.push_back('{op, length});
        if (op == OP_ALLOC)
            n_alloc++;
        else
            n_free++;
    endtask

    // Drain, let the block settle, then load a new zone
    task automatic set_zone(addr_t base, addr_t length);
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_ZONE_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_index <= REG_ZONE_LENGTH;
        cfg_data <= length;
        @(posedge clk);
        cfg_we <= 1'b0;
        zbase = base;
        zlen = length;
        live_q.delete();
        n_zones++;
    endtask

    function automatic addr_t rand48();
        return addr_t'({$urandom, $urandom});
    endfunction

    function automatic addr_t rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return rand48();
        return addr_t'(64'($urandom_range(1, 4)) * PG
                       - 64'($urandom_range(0, 1) * $urandom_range(0, 32'(PM))));
    endfunction

    // Random page of the zone, optionally past its end
    function automatic bit [63:0] zone_page(int extra);
        int zp;
        zp = ((zlen >> 21) > 4000) ? 4000 : int'(zlen >> 21);
        return 64'(zbase) + 64'($urandom_range(0, zp + extra)) * PG;
    endfunction

    task automatic random_item(bit fill);
        int     r, k;
        addr_t  hint;
        block_t b;
        r = $urandom_range(0, 99);
        if (fill && r < 60)
        begin
            // spaced frees beyond the zone: each needs a new table entry
            send(OP_FREE, addr_t'(64'(zbase) + 64'(2 * $urandom_range(0, 400) + 1) * PG
                                  + (zlen & ~addr_t'(PM))), addr_t'(PG));
        end
        else if (r < 45)
        begin
            hint = '0;
            k = $urandom_range(0, 99);
            if (k >= 45 && k < 95)
                hint = addr_t'(zone_page(0) + ($urandom_range(0, 1) ? 64'($urandom_range(0,
                               32'(PM))) : 64'd0));
            else if (k >= 95)
                hint = rand48();
            send(OP_ALLOC, hint, rand_len());
        end
        else if (r < 80 && live_q.size() > 0)
        begin
            k = $urandom_range(0, live_q.size() - 1);
            b = live_q[k];
            live_q.delete(k);
            send(OP_FREE, ($urandom_range(0, 9) != 0) ? (b.at & ~addr_t'(PM)) : b.at, b.len);
        end
        else if (r < 90)
            send(OP_FREE, addr_t'(zone_page(64)), addr_t'(64'($urandom_range(0, 3)) * PG));
        else
            send(OP_FREE, rand48(), rand48());
    endtask

    initial
    begin
        addr_t zb;
        req.valid = 1'b0;
        req.op = OP_ALLOC;
        req.address = '0;
        req.length = '0;
        cfg_we = 1'b0;
        cfg_index = REG_ZONE_BASE;
        cfg_data = '0;
        quiet = 1'b0;
        zbase = '0;
        zlen = '0;
        n_alloc = 0;
        n_free = 0;
        n_zones = 0;
        n_stat = '{0, 0, 0, 0};
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty zone out of reset: a zero-length hole at zero
        send(OP_ALLOC, '0, addr_t'(PG));
        send(OP_ALLOC, '0, '0);

        // Directed cases on a sixteen-page zone
        zb = addr_t'(64'h4000_0000);
        set_zone(zb, addr_t'(16 * PG));
        send(OP_ALLOC, '0, '0);
        send(OP_ALLOC, '0, addr_t'(1));
        send(OP_ALLOC, '0, MAX);
        send(OP_FREE, zb + 1, addr_t'(PG));
        send(OP_FREE, zb, addr_t'(PG));
        send(OP_ALLOC, zb + addr_t'(8 * PG) + 48'h123, addr_t'(PG));
        send(OP_ALLOC, zb + addr_t'(2 * PG), addr_t'(PG));
        send(OP_ALLOC, addr_t'(64'h1_0000_0000), addr_t'(PG));
        send(OP_ALLOC, zb + addr_t'(14 * PG), addr_t'(2 * PG));
        send(OP_FREE, addr_t'(64'h2000_0000), '0);
        send(OP_ALLOC, '0, '0);
        send(OP_FREE, MAX & ~addr_t'(PM), MAX);
        send(OP_FREE, '0, MAX);
        send(OP_ALLOC, MAX, addr_t'(PG));
        send(OP_ALLOC, '0, MAX);
        send(OP_FREE, rand48(), rand48());

        // Random phases over several zones, one of them filling the table
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_zone(addr_t'(64'h4000_0000), addr_t'(64 * PG));
                1: set_zone('0, MAX);
                2: set_zone(MAX & ~addr_t'(PM), addr_t'(48'h1F_FFFF));
                3: set_zone(addr_t'(48'h1234_5600_0000), addr_t'(300 * PG + 48'h777));
                4: set_zone(addr_t'(64'h8000_0000), addr_t'(32 * PG));
                default: set_zone('0, '0);
            endcase
            for (int n = 0; n < 205; n++)
            begin
                if (n % 50 == 0)
                    quiet = ($urandom_range(0, 4) == 0);
                random_item(ph == 4);
            end
        end
        quiet = 1'b0;

        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Ran %0d requests (%0d allocate, %0d free) over %0d zone settings",
                 n_alloc + n_free, n_alloc, n_free, n_zones);
        $display("Results: %0d ok, %0d no fit, %0d table full, %0d misaligned",
                 n_stat[ST_OK], n_stat[ST_NOFIT], n_stat[ST_FULL], n_stat[ST_MISALIGN]);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
